/* hdl/fed_pkg.sv */
// shared constants and controller/datapath interface types for the feedback echo delay
package fed_pkg;

    localparam int DELAY_DEPTH = 9600;
    localparam int PTR_W       = $clog2(DELAY_DEPTH);
    localparam int SAMPLE_W    = 24;
    localparam int LEVEL_W     = 12;
    localparam int ENTRY_W     = 32;
    localparam int Q_SHIFT     = 7;
    localparam int CNT_W       = 6;
    localparam int POT_STEP    = 127;
    // level / 127 estimated as (level * 516) >> 16, low by at most one
    localparam int RECIP       = 516;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = LEVEL_W + 10;
    localparam int REM_W       = LEVEL_W + 1;

    typedef struct packed {
        logic load_in;
        logic div_est;
        logic div_fix;
        logic mod_sub;
        logic cnt_set;
        logic mem_rd;
        logic mem_wr;
        logic out_echo;
        logic out_pass;
    } t_cmd;

    typedef struct packed {
        logic div_zero;
        logic mod_ge;
        logic cnt_zero;
        logic out_free;
    } t_stat;

endpackage

/* hdl/fed_ctrl.sv */
// sequencing state machine for the feedback echo delay
module fed_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  fed_pkg::t_stat i_stat,
    output fed_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_EST  = 4'd1;
    localparam logic [3:0] ST_FIX  = 4'd2;
    localparam logic [3:0] ST_MOD  = 4'd3;
    localparam logic [3:0] ST_CHK  = 4'd4;
    localparam logic [3:0] ST_RDO  = 4'd5;
    localparam logic [3:0] ST_WR   = 4'd6;
    localparam logic [3:0] ST_RDN  = 4'd7;
    localparam logic [3:0] ST_OUTE = 4'd8;
    localparam logic [3:0] ST_OUTP = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EST;
                end
            end
            ST_EST: begin
                o_cmd.div_est = 1'b1;
                n_state       = ST_FIX;
            end
            ST_FIX: begin
                o_cmd.div_fix = 1'b1;
                n_state       = ST_MOD;
            end
            ST_MOD: begin
                priority if (i_stat.div_zero) begin
                    n_state = ST_CHK;
                end else if (i_stat.mod_ge) begin
                    o_cmd.mod_sub = 1'b1;
                end else begin
                    o_cmd.cnt_set = 1'b1;
                    n_state       = ST_CHK;
                end
            end
            ST_CHK: begin
                n_state = i_stat.cnt_zero ? ST_RDO : ST_OUTP;
            end
            ST_RDO: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = ST_WR;
            end
            ST_WR: begin
                o_cmd.mem_wr = 1'b1;
                n_state      = ST_RDN;
            end
            ST_RDN: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = ST_OUTE;
            end
            ST_OUTE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_echo = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_OUTP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_pass = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |-> (r_state == ST_IDLE) && i_valid)
        else $error("item taken outside idle");
    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_wr |-> $past(o_cmd.mem_rd))
        else $error("line written without reading old entry");
    a_echo_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_cmd.out_echo) |-> $past(r_state) == ST_RDN || $past(r_state) == ST_OUTE)
        else $error("echo result without line read");
`endif

endmodule

/* hdl/fed_datapath.sv */
// delay line memory, rate divisor/counter and output register for the feedback echo delay
module fed_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [fed_pkg::SAMPLE_W-1:0]     i_raw_sample,
    input  logic [fed_pkg::LEVEL_W-1:0]      i_pot_level,
    input  fed_pkg::t_cmd                    i_cmd,
    output fed_pkg::t_stat                   o_stat,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [fed_pkg::SAMPLE_W-1:0] o_out_sample,
    output logic                             o_echo_step
);

    logic [fed_pkg::ENTRY_W-1:0]  r_mem [fed_pkg::DELAY_DEPTH];
    logic [fed_pkg::ENTRY_W-1:0]  r_rdata;
    logic                         r_rd_valid;
    logic [fed_pkg::SAMPLE_W-1:0] r_sample;
    logic [fed_pkg::LEVEL_W-1:0]  r_level;
    logic [fed_pkg::CNT_W-1:0]    r_q0;
    logic [fed_pkg::CNT_W-1:0]    r_div;
    logic [fed_pkg::CNT_W-1:0]    r_mod;
    logic [fed_pkg::CNT_W-1:0]    r_cnt;
    logic [fed_pkg::PTR_W-1:0]    r_wp;
    logic [fed_pkg::PTR_W-1:0]    n_wp;
    logic                         r_wrapped;
    logic                         r_o_valid;
    logic signed [fed_pkg::SAMPLE_W-1:0] r_out;
    logic                         r_echo;

    logic [fed_pkg::PROD_W-1:0]   w_prod;
    logic [fed_pkg::REM_W-1:0]    w_q0x;
    logic [fed_pkg::REM_W-1:0]    w_rem;
    logic [fed_pkg::ENTRY_W-1:0]  w_old;
    logic [fed_pkg::ENTRY_W-1:0]  w_half;
    logic [fed_pkg::ENTRY_W:0]    w_samp;
    logic [fed_pkg::ENTRY_W:0]    w_sum;
    logic [fed_pkg::ENTRY_W-1:0]  w_entry;
    logic [fed_pkg::ENTRY_W-1:0]  w_sh;
    logic                         w_rnd;
    logic [fed_pkg::SAMPLE_W-1:0] w_echo;

    // divisor estimate and one-step correction
    assign w_prod = fed_pkg::PROD_W'(r_level) * fed_pkg::PROD_W'(fed_pkg::RECIP);
    assign w_q0x  = fed_pkg::REM_W'(r_q0) * fed_pkg::REM_W'(fed_pkg::POT_STEP);
    assign w_rem  = fed_pkg::REM_W'(r_level) - w_q0x;

    // new entry: old / 2 toward zero plus sample in Q25.7, clamped
    assign w_old  = r_rd_valid ? r_rdata : '0;
    assign w_half = fed_pkg::ENTRY_W'($signed(w_old) >>> 1)
                  + fed_pkg::ENTRY_W'(w_old[fed_pkg::ENTRY_W-1] & w_old[0]);
    assign w_samp = {{2{r_sample[fed_pkg::SAMPLE_W-1]}}, r_sample, {fed_pkg::Q_SHIFT{1'b0}}};
    assign w_sum  = {w_half[fed_pkg::ENTRY_W-1], w_half} + w_samp;

    always_comb begin
        if (w_sum[fed_pkg::ENTRY_W] != w_sum[fed_pkg::ENTRY_W-1]) begin
            w_entry = w_sum[fed_pkg::ENTRY_W] ? {1'b1, {(fed_pkg::ENTRY_W-1){1'b0}}}
                                              : {1'b0, {(fed_pkg::ENTRY_W-1){1'b1}}};
        end else begin
            w_entry = w_sum[fed_pkg::ENTRY_W-1:0];
        end
    end

    // entry / 128 toward zero, low 24 bits
    assign w_sh   = fed_pkg::ENTRY_W'($signed(w_old) >>> fed_pkg::Q_SHIFT);
    assign w_rnd  = w_old[fed_pkg::ENTRY_W-1] & (|w_old[fed_pkg::Q_SHIFT-1:0]);
    assign w_echo = w_sh[fed_pkg::SAMPLE_W-1:0] + fed_pkg::SAMPLE_W'(w_rnd);

    assign n_wp = (r_wp == fed_pkg::PTR_W'(fed_pkg::DELAY_DEPTH - 1)) ? '0 : r_wp + 1'b1;

    assign o_stat.div_zero = (r_div == '0);
    assign o_stat.mod_ge   = (r_mod >= r_div);
    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.out_free = !r_o_valid || !i_stall;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_raw_sample;
            r_level  <= i_pot_level;
        end
        if (i_cmd.div_est) begin
            r_q0 <= w_prod[fed_pkg::PROD_W-1:fed_pkg::RECIP_SHIFT];
        end
        if (i_cmd.div_fix) begin
            r_div <= r_q0 + fed_pkg::CNT_W'(w_rem >= fed_pkg::REM_W'(fed_pkg::POT_STEP));
        end
        if (i_cmd.div_fix) begin
            r_mod <= r_cnt + 1'b1;
        end else if (i_cmd.mod_sub) begin
            r_mod <= r_mod - r_div;
        end
        if (i_cmd.out_echo) begin
            r_out  <= w_echo;
            r_echo <= 1'b1;
        end else if (i_cmd.out_pass) begin
            r_out  <= r_sample;
            r_echo <= 1'b0;
        end
    end

    // delay line memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[r_wp] <= w_entry;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[r_wp];
        end
    end

    // control state: counter, pointer, fill flag, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_wp       <= '0;
            r_wrapped  <= 1'b0;
            r_rd_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cmd.cnt_set) begin
                r_cnt <= r_mod;
            end
            if (i_cmd.mem_rd) begin
                r_rd_valid <= r_wrapped;
            end
            if (i_cmd.mem_wr) begin
                r_wp <= n_wp;
                if (n_wp == '0) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (i_cmd.out_echo || i_cmd.out_pass) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_sample = r_out;
    assign o_echo_step  = r_echo;

`ifndef SYNTHESIS
    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= fed_pkg::PTR_W'(fed_pkg::DELAY_DEPTH - 1))
        else $error("write pointer past line end");
    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mem_wr |=> (r_wp == $past(r_wp) + 1'b1) || (r_wp == '0))
        else $error("write pointer did not advance by one");
    a_cnt_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_set |=> (r_cnt < r_div))
        else $error("rate counter not reduced below divisor");
`endif

endmodule

/* hdl/feedback_echo_delay.sv */
// top level of the feedback echo delay: controller plus datapath
// Feedback echo delay. Each item carries a 24-bit two's complement sample and a
// 12-bit pot level; the pot sets a rate divisor (level / 127, 0..32) and an
// internal counter steps modulo that divisor, holding when the divisor is 0.
// On counts of zero the 9600-entry delay line (Q25.7 entries) takes
// old/2 + sample at the write pointer, the pointer advances, and the entry
// under it comes out divided by 128 toward zero with o_echo_step high;
// otherwise the sample is passed straight through with o_echo_step low.
// Exactly one result item per input item. One item is processed at a time:
// o_stall stays high from acceptance until the result is loaded, and a
// pass-through skips the line read and write. The counter modulo is iterative,
// one subtraction per step (up to 32 subtractions when a large leftover count
// meets divisor 1), and a finished result waits while the output register
// still holds an earlier result under i_stall.
// The line memory has a single port, so the old-entry read, the write and the
// new-entry read are separate states, in that order. The line needs no
// clearing pass after reset: a wrap flag marks entries never written, which
// read as zero. The output register holds a finished result while o_stall is
// already low for the next item.
module feedback_echo_delay (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [fed_pkg::SAMPLE_W-1:0]        i_raw_sample,
    input  logic [fed_pkg::LEVEL_W-1:0]         i_pot_level,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [fed_pkg::SAMPLE_W-1:0] o_out_sample,
    output logic                                o_echo_step
);

    // command and status between sequencer and datapath
    fed_pkg::t_cmd  w_cmd;
    fed_pkg::t_stat w_stat;

    // sequencer: accepts an item only when idle, then walks divisor,
    // counter modulo, line read/write and result load
    fed_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // datapath: delay line, pointer, rate counter, output register
    fed_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_raw_sample (i_raw_sample),
        .i_pot_level  (i_pot_level),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_sample (o_out_sample),
        .o_echo_step  (o_echo_step)
    );

endmodule

/* sim/tb.sv */
// self-checking testbench for the feedback echo delay, with its own echo line predictor
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT = 2000;   // cycles with no item moving on either side
    localparam int TAIL_WAIT  = 60;     // settle time after the last result

    // expected results, in arrival order, plus a private copy of the echo line state
    class t_echo_scoreboard;
        typedef struct packed {
            logic [fed_pkg::SAMPLE_W-1:0] out_word;
            logic                         echo_hit;
        } t_echo_result;

        int           errors;
        int           echo_line [fed_pkg::DELAY_DEPTH];
        int unsigned  wr_pos;
        int unsigned  rate_cnt;
        t_echo_result due_q [$];

        function new();
            errors   = 0;
            wr_pos   = 0;
            rate_cnt = 0;
            foreach (echo_line[i]) echo_line[i] = 0;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        task report_mismatch(input string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        // work out the result of one accepted item and queue it
        function void note_item(input logic [fed_pkg::SAMPLE_W-1:0] raw,
                                input logic [fed_pkg::LEVEL_W-1:0] pot);
            longint       audio;
            longint       acc;
            longint       tap;
            longint       q_one;
            int unsigned  rate_div;
            t_echo_result res;
            q_one    = longint'(1) <<< fed_pkg::Q_SHIFT;
            audio    = raw[fed_pkg::SAMPLE_W-1] ? longint'(raw) - (longint'(1) <<< fed_pkg::SAMPLE_W)
                                                : longint'(raw);
            rate_div = pot / fed_pkg::POT_STEP;
            // zero divisor holds the count, even a nonzero one
            if (rate_div != 0) rate_cnt = (rate_cnt + 1) % rate_div;
            if (rate_cnt == 0) begin
                // longint division truncates toward zero, which is the halving we want
                acc = longint'(echo_line[wr_pos]) / 2 + audio * q_one;
                if (acc > longint'(32'sh7FFFFFFF)) acc = longint'(32'sh7FFFFFFF);
                if (acc < -longint'(32'sh7FFFFFFF) - 1) acc = -longint'(32'sh7FFFFFFF) - 1;
                echo_line[wr_pos] = int'(acc);
                wr_pos = (wr_pos + 1 >= fed_pkg::DELAY_DEPTH) ? 0 : wr_pos + 1;
                tap = longint'(echo_line[wr_pos]) / q_one;
                res.out_word = tap[fed_pkg::SAMPLE_W-1:0];
                res.echo_hit = 1'b1;
            end else begin
                res.out_word = raw;
                res.echo_hit = 1'b0;
            end
            due_q.push_back(res);
        endfunction

        task check_result(input logic [fed_pkg::SAMPLE_W-1:0] got_word, input logic got_hit);
            t_echo_result res;
            if (due_q.size() == 0) begin
                report_mismatch($sformatf("result %h/%b with nothing expected", got_word, got_hit));
            end else begin
                res = due_q.pop_front();
                if (got_word !== res.out_word)
                    report_mismatch($sformatf("out_sample %h, expected %h", got_word, res.out_word));
                if (got_hit !== res.echo_hit)
                    report_mismatch($sformatf("echo_step %b, expected %b", got_hit, res.echo_hit));
            end
        endtask
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic [fed_pkg::SAMPLE_W-1:0]        i_raw_sample;
    logic [fed_pkg::LEVEL_W-1:0]         i_pot_level;
    logic                                o_valid;
    logic                                i_stall;
    logic signed [fed_pkg::SAMPLE_W-1:0] o_out_sample;
    logic                                o_echo_step;

    t_echo_scoreboard sb;
    bit               no_idle;    // when set neither side inserts gaps or stalls

    feedback_echo_delay dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_raw_sample (i_raw_sample),
        .i_pot_level  (i_pot_level),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_sample (o_out_sample),
        .o_echo_step  (o_echo_step)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // gap length before the next item: mostly short, now and then long
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // audio word: mostly uniform, sometimes one of the corner values
    function logic [fed_pkg::SAMPLE_W-1:0] pick_raw();
        if ($urandom_range(0, 9) < 7)
            return fed_pkg::SAMPLE_W'($urandom_range(0, 24'hFFFFFF));
        case ($urandom_range(0, 5))
            0:       return 24'h000000;
            1:       return 24'h000001;
            2:       return 24'h7FFFFF;
            3:       return 24'h800000;
            4:       return 24'h800001;
            default: return 24'hFFFFFF;
        endcase
    endfunction

    // pot level: full range, or biased toward small divisors so echo updates stay common
    function logic [fed_pkg::LEVEL_W-1:0] pick_pot();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return fed_pkg::LEVEL_W'($urandom_range(0, 4095));
        if (r < 7) return fed_pkg::LEVEL_W'($urandom_range(0, 2 * fed_pkg::POT_STEP - 1));
        return fed_pkg::LEVEL_W'($urandom_range(fed_pkg::POT_STEP, 10 * fed_pkg::POT_STEP));
    endfunction

    // entered and left at a falling edge; holds the item until it is taken
    task send_item(input logic [fed_pkg::SAMPLE_W-1:0] raw,
                   input logic [fed_pkg::LEVEL_W-1:0] pot, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_raw_sample <= raw;
        i_pot_level  <= pot;
        i_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(raw, pot);
        @(negedge i_clk);
    endtask

    // hold off the sender until every queued result has come back
    task drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // result side: compare every item taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_out_sample, o_echo_step);
    end

    // receiver stalls: free runs and stall bursts of varied length
    initial begin
        int r;
        int len;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (no_idle) begin
                i_stall <= 1'b0;
                @(negedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    i_stall <= 1'b0;
                    len = $urandom_range(1, 8);
                end else begin
                    i_stall <= 1'b1;
                    if (r < 88)      len = $urandom_range(1, 3);
                    else if (r < 97) len = $urandom_range(4, 12);
                    else             len = $urandom_range(20, 60);
                end
                repeat (len) @(negedge i_clk);
            end
        end
    end

    // watchdog: too long with no item moving on either side ends the run
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // main sequence
    initial begin
        int n;
        sb           = new();
        no_idle      = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_raw_sample = '0;
        i_pot_level  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, divisor edges, held and leftover counts
        send_item(24'h000000, 12'd0,    0);     // zero divisor, count at zero: update
        send_item(24'h7FFFFF, 12'd0,    1);
        send_item(24'h800000, 12'd126,  0);     // just below one step
        send_item(24'hFFFFFF, 12'd127,  0);     // divisor 1
        send_item(24'h000001, 12'd4095, 2);     // divisor 32, count 1: pass
        send_item(24'hFFFFFE, 12'd4095, 0);     // count 2
        send_item(24'h800001, 12'd4095, 0);     // count 3
        send_item(24'h5A5A5A, 12'd100,  0);     // zero divisor holds a nonzero count
        send_item(24'hA5A5A5, 12'd0,    3);
        send_item(24'h7FFFFF, 12'd4064, 0);     // divisor 32, count 4
        send_item(24'h0F0F0F, 12'd4063, 0);     // divisor 31, count 5
        send_item(24'h800000, 12'd254,  0);     // leftover count wraps in divisor 2
        send_item(24'hFFFFFF, 12'd253,  0);     // divisor 1
        send_item(24'h000080, 12'd381,  1);     // divisor 3, count 1
        send_item(24'hFFFF80, 12'd508,  0);     // divisor 4, count 2
        send_item(24'h00007F, 12'd381,  0);     // divisor 3, back to zero
        send_item(24'hFFFF81, 12'd2540, 0);     // divisor 20
        send_item(24'h400000, 12'd2539, 0);     // divisor 19
        send_item(24'hC00000, 12'd255,  0);     // divisor 2, leftover count equal to it
        send_item(24'h000000, 12'd4095, 5);
        drain_results();

        // random, first part
        for (n = 0; n < 600; n++) begin
            no_idle = ((n % 200) >= 160);
            send_item(pick_raw(), pick_pot(), pick_gap());
        end
        no_idle = 1'b0;
        drain_results();

        // long run of line updates: every item updates, mostly back to back
        send_item(pick_raw(),
                  fed_pkg::LEVEL_W'($urandom_range(fed_pkg::POT_STEP, 2 * fed_pkg::POT_STEP - 1)),
                  0);
        for (n = 0; n < 700; n++) begin
            no_idle = (n < 500);
            send_item(pick_raw(),
                      fed_pkg::LEVEL_W'($urandom_range(0, 2 * fed_pkg::POT_STEP - 1)),
                      pick_gap());
        end

        // random, second part
        for (n = 0; n < 580; n++) begin
            no_idle = ((n % 200) >= 160);
            send_item(pick_raw(), pick_pot(), pick_gap());
        end
        no_idle = 1'b0;
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/fed_pkg.sv
hdl/fed_ctrl.sv
hdl/fed_datapath.sv
hdl/feedback_echo_delay.sv
sim/tb.sv
